/* rtl/ffba_pkg.sv */
package ffba_pkg;

    // Field widths of the request and result transactions
    localparam int REQ_W     = 16;
    localparam int OFF_OUT_W = 10;
    localparam int STATUS_W  = 2;

    // Rounded size can reach 65536, one bit wider than the request
    localparam int NEED_W = REQ_W + 1;
    // Room check: top + header + need, all below 2**SUM_W
    localparam int SUM_W  = NEED_W + 1;

    // Payload granularity
    localparam logic [NEED_W-1:0] ALIGN_ADD  = NEED_W'(7);
    localparam logic [NEED_W-1:0] ALIGN_MASK = ~NEED_W'(7);

    // Command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OOM     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd3;

    typedef struct packed {
        logic                 cmd;
        logic [REQ_W-1:0]     request_size;
        logic [OFF_OUT_W-1:0] free_offset;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [OFF_OUT_W-1:0] payload_offset;
        logic                 reused;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic scan_en;
        logic take_hit;
        logic take_miss;
        logic load_out;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_null;
        logic hit;
        logic done;
        logic out_free;
    } ctl_sts_t;

endpackage

/* rtl/ffba_ram.sv */
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/ffba_ctrl.sv */
module ffba_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ffba_pkg::ctl_sts_t sts,
    output ffba_pkg::ctl_cmd_t cmd
);

    import ffba_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Sequence one transaction: accept, walk the table, hand off the result
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = sts.is_null ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (sts.hit)
                begin
                    cmd.take_hit = 1'b1;
                    state_next   = S_FINISH;
                end
                else if (sts.done)
                begin
                    cmd.take_miss = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A scan ends by a hit or a miss, never both
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.take_hit && cmd.take_miss))
        else $error("hit and miss in the same cycle");

    // The result moves only into a free output slot
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("output register overwritten");

    // A scan that ends always leads to the output handoff
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take_hit || cmd.take_miss) |=> (state_reg == S_FINISH))
        else $error("scan end did not reach finish");

endmodule

/* rtl/ffba_datapath.sv */
module ffba_datapath #(
    parameter int HEAP_BYTES   = 1024,
    parameter int HEADER_BYTES = 24,
    parameter int MAX_BLOCKS   = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ffba_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output ffba_pkg::out_item_t out_data,
    input  ffba_pkg::ctl_cmd_t  cmd,
    output ffba_pkg::ctl_sts_t  sts
);

    import ffba_pkg::*;

    localparam int OFF_W = $clog2(HEAP_BYTES + 1);
    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int ENT_W = 2 * OFF_W + 1;

    // Request held for the duration of the transaction
    logic                 op_reg;
    logic [NEED_W-1:0]    need_reg;
    logic [OFF_OUT_W-1:0] offset_reg;

    // Table walk
    logic [CNT_W-1:0] scan_idx_reg;
    logic [CNT_W-1:0] scan_idx_next;
    logic             pend_reg;
    logic             pend_next;
    logic [IDX_W-1:0] pend_idx_reg;

    // Heap bookkeeping
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [OFF_W-1:0] top_reg;
    logic [OFF_W-1:0] top_next;

    // Results
    out_item_t res_reg;
    out_item_t res_next;
    out_item_t out_reg;
    logic      out_valid_reg;
    logic      out_valid_next;

    // Table memory
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;
    logic             rd_en;
    logic [ENT_W-1:0] rd_data;

    logic             ent_free;
    logic [OFF_W-1:0] ent_size;
    logic [OFF_W-1:0] ent_start;

    logic              more;
    logic              hit;
    logic [NEED_W-1:0] in_need;
    logic [SUM_W-1:0]  end_sum;
    logic              fits;
    logic [OFF_W-1:0]  new_start;

    ffba_ram #(
        .WIDTH(ENT_W),
        .DEPTH(MAX_BLOCKS)
    ) u_table (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(scan_idx_reg[IDX_W-1:0]),
        .rd_data(rd_data)
    );

    assign ent_free  = rd_data[0];
    assign ent_size  = rd_data[OFF_W:1];
    assign ent_start = rd_data[2*OFF_W:OFF_W+1];

    // Round the request up to the payload granularity
    assign in_need = (NEED_W'(in_data.request_size) + ALIGN_ADD) & ALIGN_MASK;

    // Compare the entry read last cycle
    assign more = (scan_idx_reg < count_reg);
    always_comb
    begin
        if (op_reg == CMD_ALLOC)
        begin
            hit = ent_free && (NEED_W'(ent_size) >= need_reg);
        end
        else
        begin
            hit = (NEED_W'(ent_start) == NEED_W'(offset_reg));
        end
        hit = hit && cmd.scan_en && pend_reg;
    end

    assign rd_en = cmd.scan_en && !hit && more;

    // Room for a new block at the top of the heap
    assign end_sum   = SUM_W'(top_reg) + SUM_W'(HEADER_BYTES) + SUM_W'(need_reg);
    assign fits      = (count_reg < CNT_W'(MAX_BLOCKS)) && (end_sum <= SUM_W'(HEAP_BYTES));
    assign new_start = OFF_W'(SUM_W'(top_reg) + SUM_W'(HEADER_BYTES));

    assign sts.is_null  = (in_data.cmd == CMD_ALLOC) ? (in_data.request_size == '0)
                                                     : (in_data.free_offset == '0);
    assign sts.hit      = hit;
    assign sts.done     = cmd.scan_en && !pend_reg && !more;
    assign sts.out_free = !out_valid_reg || out_ready;

    // Next-state logic for table writes, bookkeeping and the result
    always_comb
    begin
        wr_en          = 1'b0;
        wr_addr        = pend_idx_reg;
        wr_data        = rd_data;
        count_next     = count_reg;
        top_next       = top_reg;
        res_next       = res_reg;
        scan_idx_next  = scan_idx_reg;
        pend_next      = 1'b0;
        out_valid_next = out_valid_reg;

        if (cmd.accept)
        begin
            scan_idx_next = '0;
            res_next      = '{status: ST_NULL, payload_offset: '0, reused: 1'b0};
        end

        if (rd_en)
        begin
            scan_idx_next = scan_idx_reg + CNT_W'(1);
            pend_next     = 1'b1;
        end

        // Claim or release the matching block
        if (cmd.take_hit)
        begin
            wr_en   = 1'b1;
            wr_data = {ent_start, ent_size, (op_reg == CMD_FREE)};
            if (op_reg == CMD_ALLOC)
            begin
                res_next = '{status: ST_OK, payload_offset: OFF_OUT_W'(ent_start),
                             reused: 1'b1};
            end
            else
            begin
                res_next = '{status: ST_OK, payload_offset: '0, reused: 1'b0};
            end
        end

        // Append a new block, or report the failure
        if (cmd.take_miss)
        begin
            if (op_reg == CMD_FREE)
            begin
                res_next = '{status: ST_UNKNOWN, payload_offset: '0, reused: 1'b0};
            end
            else if (fits)
            begin
                wr_en      = 1'b1;
                wr_addr    = count_reg[IDX_W-1:0];
                wr_data    = {new_start, OFF_W'(need_reg), 1'b0};
                count_next = count_reg + CNT_W'(1);
                top_next   = OFF_W'(end_sum);
                res_next   = '{status: ST_OK, payload_offset: OFF_OUT_W'(new_start),
                               reused: 1'b0};
            end
            else
            begin
                res_next = '{status: ST_OOM, payload_offset: '0, reused: 1'b0};
            end
        end

        // Output register handshake
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            top_reg       <= '0;
            pend_reg      <= 1'b0;
            scan_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            top_reg       <= top_next;
            pend_reg      <= pend_next;
            scan_idx_reg  <= scan_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg     <= in_data.cmd;
            need_reg   <= in_need;
            offset_reg <= in_data.free_offset;
        end
        if (rd_en)
        begin
            pend_idx_reg <= scan_idx_reg[IDX_W-1:0];
        end
        res_reg <= res_next;
        if (cmd.load_out)
        begin
            out_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // The table never holds more blocks than it has entries
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("block count overflow");

    // The top of the heap never passes its end
    assert property (@(posedge clk) disable iff (!rst_n)
        SUM_W'(top_reg) <= SUM_W'(HEAP_BYTES))
        else $error("heap top overflow");

    // An append grows the table by exactly one block
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take_miss && op_reg == CMD_ALLOC && fits)
            |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("append did not advance block count");

endmodule

/* rtl/first_fit_block_allocator.sv */
// First-fit block allocator over a fixed heap.
// Input channel (in_valid/in_ready/in_data): one transaction per request,
// cmd selects allocate or free; request_size is used by allocate and
// free_offset by free. Output channel (out_valid/out_ready/out_data): one
// result transaction per request, in request order.
// A request walks the block table in a single RAM, one entry per cycle,
// through its registered read port. A request is first accepted, then
// walks the table until it stops at a matching entry or has passed every
// block in the table, and then moves its result into the output register.
// A null request skips the walk and goes straight to the output handoff.
// The table walk sets the throughput; one request is in work at a time.
// Reset empties the table and the heap at once; no clearing pass runs.
// While the receiver stalls, the result is held in the output register and
// the next request is still accepted and processed; it waits at its end
// until the output register is taken.
module first_fit_block_allocator #(
    parameter int HEAP_BYTES   = 1024,
    parameter int HEADER_BYTES = 24,
    parameter int MAX_BLOCKS   = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ffba_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output ffba_pkg::out_item_t out_data
);

    import ffba_pkg::*;

    ctl_cmd_t ctl_cmd;
    ctl_sts_t ctl_sts;

    ffba_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .sts     (ctl_sts),
        .cmd     (ctl_cmd)
    );

    ffba_datapath #(
        .HEAP_BYTES  (HEAP_BYTES),
        .HEADER_BYTES(HEADER_BYTES),
        .MAX_BLOCKS  (MAX_BLOCKS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cmd      (ctl_cmd),
        .sts      (ctl_sts)
    );

endmodule
